/* hdl/tds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task dependency scoreboard package
// Shared sizes, command codes and the beat types of both channels.
// ----------------------------------------------------------------------------
package tds_pkg;

    // Task capacity of the scoreboard.
    localparam int MAX_TASKS = 32;

    // Fixed field widths of the beats.
    localparam int CMD_W  = 3;
    localparam int TASK_W = 5;
    localparam int DEP_W  = 32;

    // Rows actually held: a task number can never exceed the task field.
    localparam int ROWS  = (MAX_TASKS < (1 << TASK_W)) ? MAX_TASKS : (1 << TASK_W);
    localparam int IDX_W = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int CNT_W = $clog2(ROWS + 1);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEFINE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ASSIGN   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TASK_W-1:0] task_req;
        logic [DEP_W-1:0]  dep_mask;
    } in_beat_t;

    typedef struct packed {
        logic [TASK_W-1:0] ready_task;
        logic              has_task;
        logic              last;
    } out_beat_t;

endpackage

/* hdl/tds_row_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dependency row memory
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tds_row_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = 5
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/tds_row_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row readiness check
// Decides whether one task is ready from its row and its marks.
// ----------------------------------------------------------------------------
module tds_row_check (
    input  logic [tds_pkg::DEP_W-1:0] dep_row,
    input  logic                      defined_bit,
    input  logic                      assigned_bit,
    input  logic [tds_pkg::ROWS-1:0]  completed,
    output logic                      task_ready
);

    logic [tds_pkg::DEP_W-1:0] completed_ext;
    logic [tds_pkg::DEP_W-1:0] pending;

    // Dependencies beyond the held rows can never be completed.
    assign completed_ext = tds_pkg::DEP_W'(completed);
    assign pending       = dep_row & ~completed_ext;
    assign task_ready    = defined_bit & ~assigned_bit & (pending == '0);

endmodule

/* hdl/task_dependency_scoreboard_unit.sv */
// A query sweeps the row memory through its one read port, then walks
// the ready vector row by row while results are handed out, and result
// back-pressure can hold it. Only one query runs at a time; input is held
// off until its final beat.
// Reset (aresetn low, synchronous) clears all marks, the sequencer and m_valid.
// ----------------------------------------------------------------------------
// Task dependency scoreboard
// Keeps dependency rows and per-task marks and lists the ready tasks on query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module task_dependency_scoreboard_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tds_pkg::in_beat_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output tds_pkg::out_beat_t m_payload
);

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Per-task marks. The rows themselves need no clearing: a row is only
    // ever consulted for a task whose defined mark is set, and defining a
    // task always writes its row first.
    logic [tds_pkg::ROWS-1:0] defined_reg,   defined_next;
    logic [tds_pkg::ROWS-1:0] completed_reg, completed_next;
    logic [tds_pkg::ROWS-1:0] assigned_reg,  assigned_next;

    // Sweep counter, the index of the row whose data is now on the read port,
    // and the ready vector that is built during the sweep and then walked.
    logic [tds_pkg::CNT_W-1:0] cnt_reg,    cnt_next;
    logic [tds_pkg::IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [tds_pkg::ROWS-1:0]  vec_reg,    vec_next;
    logic [tds_pkg::IDX_W-1:0] out_idx_reg, out_idx_next;

    // Output register, which lets a finished beat wait without stalling.
    logic               m_valid_reg,   m_valid_next;
    tds_pkg::out_beat_t m_payload_reg, m_payload_next;

    logic                      s_fire;
    logic                      slot_free;
    logic                      task_in_range;
    logic [tds_pkg::IDX_W-1:0] task_idx;
    logic                      ram_wr_en;
    logic                      ram_rd_en;
    logic [tds_pkg::IDX_W-1:0] ram_rd_addr;
    logic [tds_pkg::DEP_W-1:0] ram_rd_data;
    logic                      row_ready;
    logic [tds_pkg::ROWS-1:0]  vec_shift;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid & s_ready;
    assign slot_free = ~m_valid_reg | m_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Task numbers at or above the row count are ignored by every command.
    assign task_in_range = ({1'b0, s_payload.task_req} < (tds_pkg::TASK_W + 1)'(tds_pkg::ROWS));
    assign task_idx      = s_payload.task_req[tds_pkg::IDX_W-1:0];

    // A redefinition leaves the existing row untouched.
    assign ram_wr_en = s_fire && (s_payload.command == tds_pkg::CMD_DEFINE)
                       && task_in_range && !defined_reg[task_idx];

    // The sweep issues one row read per cycle; the final sweep cycle only
    // consumes the data of the last row.
    assign ram_rd_en   = (state_reg == ST_SCAN) && (cnt_reg < tds_pkg::CNT_W'(tds_pkg::ROWS));
    assign ram_rd_addr = cnt_reg[tds_pkg::IDX_W-1:0];

    assign vec_shift = vec_reg >> 1;

    tds_row_ram #(
        .DEPTH (tds_pkg::ROWS),
        .WIDTH (tds_pkg::DEP_W),
        .AW    (tds_pkg::IDX_W)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (task_idx),
        .wr_data (s_payload.dep_mask),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The one readiness check, reused for every row in turn.
    tds_row_check u_row_check (
        .dep_row      (ram_rd_data),
        .defined_bit  (defined_reg[rd_idx_reg]),
        .assigned_bit (assigned_reg[rd_idx_reg]),
        .completed    (completed_reg),
        .task_ready   (row_ready)
    );

    always_comb begin
        state_next     = state_reg;
        defined_next   = defined_reg;
        completed_next = completed_reg;
        assigned_next  = assigned_reg;
        cnt_next       = cnt_reg;
        rd_idx_next    = rd_idx_reg;
        vec_next       = vec_reg;
        out_idx_next   = out_idx_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        m_payload_next = m_payload_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_payload.command)
                        tds_pkg::CMD_CLEAR: begin
                            defined_next   = '0;
                            completed_next = '0;
                            assigned_next  = '0;
                        end
                        tds_pkg::CMD_DEFINE: begin
                            if (ram_wr_en) begin
                                defined_next[task_idx] = 1'b1;
                            end
                        end
                        tds_pkg::CMD_COMPLETE: begin
                            if (task_in_range) begin
                                completed_next[task_idx] = 1'b1;
                            end
                        end
                        tds_pkg::CMD_ASSIGN: begin
                            if (task_in_range) begin
                                assigned_next[task_idx] = 1'b1;
                            end
                        end
                        tds_pkg::CMD_QUERY: begin
                            cnt_next   = '0;
                            state_next = ST_SCAN;
                        end
                        default: begin
                            // Unused codes have no effect.
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // The row read last cycle is judged now and enters the ready
                // vector from the top; after the full sweep row 0 sits in bit 0.
                if (cnt_reg != '0) begin
                    vec_next = {row_ready, vec_reg[tds_pkg::ROWS-1:1]};
                end
                rd_idx_next = ram_rd_addr;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == tds_pkg::CNT_W'(tds_pkg::ROWS)) begin
                    out_idx_next = '0;
                    state_next   = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (vec_reg == '0) begin
                    // Nothing ready: one empty, final beat.
                    if (slot_free) begin
                        m_valid_next              = 1'b1;
                        m_payload_next.ready_task = '0;
                        m_payload_next.has_task   = 1'b0;
                        m_payload_next.last       = 1'b1;
                        state_next                = ST_IDLE;
                    end
                end else if (!vec_reg[0]) begin
                    vec_next     = vec_shift;
                    out_idx_next = out_idx_reg + 1'b1;
                end else if (slot_free) begin
                    m_valid_next              = 1'b1;
                    m_payload_next.ready_task = tds_pkg::TASK_W'(out_idx_reg);
                    m_payload_next.has_task   = 1'b1;
                    m_payload_next.last       = (vec_shift == '0);
                    vec_next                  = vec_shift;
                    out_idx_next              = out_idx_reg + 1'b1;
                    if (vec_shift == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            defined_reg   <= '0;
            completed_reg <= '0;
            assigned_reg  <= '0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            defined_reg   <= defined_next;
            completed_reg <= completed_next;
            assigned_reg  <= assigned_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        vec_reg       <= vec_next;
        out_idx_reg   <= out_idx_next;
        m_payload_reg <= m_payload_next;
    end

endmodule

/* hdl/tds_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scoreboard port checker
// Watches the top-level ports for handshake and result-sequence slips.
// ----------------------------------------------------------------------------
module tds_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input tds_pkg::in_beat_t  s_payload,
    input logic               m_valid,
    input logic               m_ready,
    input tds_pkg::out_beat_t m_payload
);

    // A stalled result beat stays put.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result beat changed while stalled");

    // While a query still has beats to give, no new command is taken.
    a_busy_mid_query: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.last |-> !s_ready)
        else $error("input ready in the middle of a query");

    // An empty answer is a single final beat with task number zero.
    a_empty_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.has_task |-> m_payload.last && (m_payload.ready_task == '0))
        else $error("malformed empty query answer");

    // An accepted query occupies the block in the following cycle.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_payload.command == tds_pkg::CMD_QUERY) |=> !s_ready)
        else $error("input ready straight after a query");

endmodule

bind task_dependency_scoreboard_unit tds_checker u_tds_checker (.*);

/* dv/tb_task_dependency_scoreboard_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task dependency scoreboard testbench
// Drives command beats into the scoreboard with random gaps, holds off result
// beats at random, and checks every result against a behavioural copy of the
// task table that is updated as each command beat is accepted.
// ----------------------------------------------------------------------------
module tb_task_dependency_scoreboard_unit;

    // Task numbers that the five-bit task field can carry.
    localparam int SLOTS = 1 << tds_pkg::TASK_W;

    // Command codes that the block must ignore.
    localparam logic [tds_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [tds_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // Run length: the random part stops once this many beats have gone in,
    // and the final stretch runs with no idling on either side.
    localparam int ITEM_TARGET  = 120;
    localparam int CALM_ITEMS   = 20;
    // Drain time, sized for a query to sweep the rows and walk the ready vector.
    localparam int DRAIN_CYCLES = 80;
    // Watchdog limit, set with a wide margin over the worst-case run.
    localparam int CYCLE_LIMIT  = 500000;

    // Behavioural copy of the task table. Each accepted command beat is
    // applied to it, and a query queues the result beats that it must give.
    class ready_set_tracker;
        logic [tds_pkg::DEP_W-1:0] dep_rows [SLOTS];
        logic [SLOTS-1:0]          defined_set;
        logic [SLOTS-1:0]          completed_set;
        logic [SLOTS-1:0]          assigned_set;
        tds_pkg::out_beat_t        ready_beats_due [$];
        int                        mismatches;

        function new();
            wipe();
            mismatches = 0;
        endfunction

        function void wipe();
            foreach (dep_rows[i]) dep_rows[i] = '0;
            defined_set   = '0;
            completed_set = '0;
            assigned_set  = '0;
        endfunction

        function void absorb_command(tds_pkg::in_beat_t beat);
            int                 slot;
            bit                 found;
            tds_pkg::out_beat_t r;
            slot  = int'(beat.task_req);
            found = 1'b0;
            case (beat.command)
                tds_pkg::CMD_CLEAR: wipe();
                tds_pkg::CMD_DEFINE: begin
                    // A second definition of the same task leaves its row alone.
                    if (slot < tds_pkg::MAX_TASKS && !defined_set[slot]) begin
                        dep_rows[slot]    = beat.dep_mask;
                        defined_set[slot] = 1'b1;
                    end
                end
                tds_pkg::CMD_COMPLETE: begin
                    if (slot < tds_pkg::MAX_TASKS) completed_set[slot] = 1'b1;
                end
                tds_pkg::CMD_ASSIGN: begin
                    if (slot < tds_pkg::MAX_TASKS) assigned_set[slot] = 1'b1;
                end
                tds_pkg::CMD_QUERY: begin
                    for (int i = 0; i < tds_pkg::MAX_TASKS && i < SLOTS; i++) begin
                        if (defined_set[i] && !assigned_set[i] &&
                            (dep_rows[i] & ~completed_set) == '0) begin
                            r.ready_task = tds_pkg::TASK_W'(i);
                            r.has_task   = 1'b1;
                            r.last       = 1'b0;
                            ready_beats_due = {ready_beats_due, r};
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        r = ready_beats_due[$];
                        r.last = 1'b1;
                        ready_beats_due[$] = r;
                    end else begin
                        r.ready_task = '0;
                        r.has_task   = 1'b0;
                        r.last       = 1'b1;
                        ready_beats_due = {ready_beats_due, r};
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_ready_beat(tds_pkg::out_beat_t got);
            tds_pkg::out_beat_t want;
            if (ready_beats_due.size() == 0) begin
                $display("%0t: result beat with nothing expected: %s=%0d %s=%0b %s=%0b",
                         $time, "ready_task", got.ready_task, "has_task", got.has_task,
                         "last", got.last);
                mismatches++;
                return;
            end
            want = ready_beats_due.pop_front();
            if (got.ready_task !== want.ready_task) begin
                $display("%0t: ready_task expected %0d actual %0d",
                         $time, want.ready_task, got.ready_task);
                mismatches++;
            end
            if (got.has_task !== want.has_task) begin
                $display("%0t: has_task expected %0b actual %0b",
                         $time, want.has_task, got.has_task);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return ready_beats_due.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    tds_pkg::in_beat_t  s_payload;
    logic               m_valid;
    logic               m_ready;
    tds_pkg::out_beat_t m_payload;

    ready_set_tracker tracker = new();

    // Idling odds: a gap or stall starts with probability 1/odds, never at 0.
    int unsigned tx_gap_odds   = 0;
    int unsigned rx_stall_odds = 0;
    bit          calm          = 1'b0;
    int          items_sent    = 0;
    int          cycle_count   = 0;

    task_dependency_scoreboard_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // 12 ns clock.
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("task_dependency_scoreboard_unit verification failed");
            $finish;
        end
    end

    // Result side back-pressure. Stalls start at random and come in bursts,
    // and m_ready is only ever assigned once per clock edge.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!calm && rx_stall_odds != 0 && $urandom_range(1, rx_stall_odds) == 1) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Result monitor. Signals are read at the edge, before any update made
    // at that edge, so they hold exactly what the block sampled.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_ready_beat(m_payload);
    end

    function automatic tds_pkg::in_beat_t pack_command(int cmd, int slot,
                                                       logic [tds_pkg::DEP_W-1:0] mask);
        tds_pkg::in_beat_t beat;
        beat.command  = tds_pkg::CMD_W'(cmd);
        beat.task_req = tds_pkg::TASK_W'(slot);
        beat.dep_mask = mask;
        return beat;
    endfunction

    function automatic int unsigned pick_odds();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 2;
            2: return 4;
            default: return 12;
        endcase
    endfunction

    // Mostly a task already in the episode, now and then any task at all.
    function automatic int pick_task(logic [SLOTS-1:0] pool);
        int slot;
        slot = $urandom_range(0, SLOTS - 1);
        if (pool != '0 && $urandom_range(0, 4) != 0) begin
            while (!pool[slot]) slot = $urandom_range(0, SLOTS - 1);
        end
        return slot;
    endfunction

    // Dependencies are usually a sparse subset of tasks defined earlier in
    // the episode, which keeps the graph acyclic; sometimes the mask is
    // fully random, empty, or includes the task itself.
    function automatic logic [tds_pkg::DEP_W-1:0] pick_deps(logic [SLOTS-1:0] pool, int slot);
        logic [tds_pkg::DEP_W-1:0] deps;
        deps = tds_pkg::DEP_W'(pool) & $urandom() & $urandom();
        case ($urandom_range(0, 9))
            0: deps = $urandom();
            1: deps[slot] = 1'b1;
            2: deps = '0;
            default: ;
        endcase
        return deps;
    endfunction

    // Presents one command beat and returns at the edge where it is taken.
    // A gap, when one is drawn, lowers valid first; otherwise valid simply
    // stays high into the next beat.
    task automatic push_command(input tds_pkg::in_beat_t beat);
        calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
        if (!calm && tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= beat;
        do @(posedge aclk); while (!s_ready);
        tracker.absorb_command(beat);
        items_sent++;
    endtask

    // Hand-picked sequence covering the corner cases of the table.
    task automatic run_directed();
        // Nothing defined yet, so the query gives the single empty beat.
        push_command(pack_command(tds_pkg::CMD_QUERY, 0, '0));
        push_command(pack_command(tds_pkg::CMD_DEFINE, 0, '0));
        // Highest task depends on every task, itself included.
        push_command(pack_command(tds_pkg::CMD_DEFINE, 31, '1));
        // Self dependency: ready only once the task itself is completed.
        push_command(pack_command(tds_pkg::CMD_DEFINE, 5, 32'h0000_0020));
        // Redefinition must be ignored, so task 0 stays free of dependencies.
        push_command(pack_command(tds_pkg::CMD_DEFINE, 0, 32'h0000_0002));
        // Completing a task that was never defined still satisfies others.
        push_command(pack_command(tds_pkg::CMD_COMPLETE, 7, '0));
        push_command(pack_command(tds_pkg::CMD_DEFINE, 10, 32'h0000_0080));
        // Assigned before it is defined: it must never be listed.
        push_command(pack_command(tds_pkg::CMD_ASSIGN, 12, '0));
        push_command(pack_command(tds_pkg::CMD_DEFINE, 12, '0));
        push_command(pack_command(tds_pkg::CMD_DEFINE, 3, '0));
        push_command(pack_command(tds_pkg::CMD_QUERY, 0, '0));
        push_command(pack_command(tds_pkg::CMD_COMPLETE, 5, '0));
        // A completed task that is not yet assigned is still listed.
        push_command(pack_command(tds_pkg::CMD_COMPLETE, 3, '0));
        push_command(pack_command(tds_pkg::CMD_QUERY, 31, '1));
        push_command(pack_command(tds_pkg::CMD_ASSIGN, 0, '0));
        // Spare codes must neither change the table nor give a result.
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) begin
            push_command(pack_command(c, $urandom_range(0, SLOTS - 1), $urandom()));
        end
        push_command(pack_command(tds_pkg::CMD_QUERY, 0, '0));
        push_command(pack_command(tds_pkg::CMD_CLEAR, 0, '0));
        push_command(pack_command(tds_pkg::CMD_QUERY, 0, '0));
    endtask

    // Every task defined with no dependencies: one query lists all of them,
    // then a few are handed out and the list is asked for again.
    task automatic run_full_table();
        push_command(pack_command(tds_pkg::CMD_CLEAR, 0, '0));
        for (int k = 0; k < SLOTS; k++) begin
            push_command(pack_command(tds_pkg::CMD_DEFINE, k, '0));
        end
        push_command(pack_command(tds_pkg::CMD_QUERY, 0, '0));
        repeat ($urandom_range(1, 4)) begin
            push_command(pack_command(tds_pkg::CMD_ASSIGN, $urandom_range(0, SLOTS - 1), '0));
        end
        push_command(pack_command(tds_pkg::CMD_QUERY, 0, '0));
    endtask

    // A well-formed scheduling round: define a handful of tasks, then mix
    // completions, assignments, late definitions and queries.
    task automatic run_episode();
        logic [SLOTS-1:0] pool;
        int               slot;
        pool = '0;
        // Usually start from a clean table, sometimes build on what is there.
        if ($urandom_range(0, 2) != 0) push_command(pack_command(tds_pkg::CMD_CLEAR, 0, '0));
        repeat ($urandom_range(2, 8)) begin
            slot = $urandom_range(0, SLOTS - 1);
            push_command(pack_command(tds_pkg::CMD_DEFINE, slot, pick_deps(pool, slot)));
            pool[slot] = 1'b1;
        end
        push_command(pack_command(tds_pkg::CMD_QUERY, $urandom_range(0, SLOTS - 1),
                                  $urandom()));
        repeat ($urandom_range(3, 8)) begin
            slot = pick_task(pool);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    push_command(pack_command(tds_pkg::CMD_COMPLETE, slot, $urandom()));
                end
                5, 6: push_command(pack_command(tds_pkg::CMD_ASSIGN, slot, $urandom()));
                7: begin
                    push_command(pack_command(tds_pkg::CMD_DEFINE, slot, pick_deps(pool, slot)));
                    pool[slot] = 1'b1;
                end
                default: push_command(pack_command(tds_pkg::CMD_QUERY, slot, $urandom()));
            endcase
        end
        push_command(pack_command(tds_pkg::CMD_QUERY, 0, '0));
    endtask

    task automatic run_random();
        bit filled;
        filled = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            // Fresh idling odds each round, so some rounds run with none.
            tx_gap_odds   = pick_odds();
            rx_stall_odds = pick_odds();
            if (!filled) begin
                run_full_table();
                filled = 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                // Noise: any code, any task, any mask.
                repeat ($urandom_range(3, 8)) begin
                    push_command(pack_command($urandom_range(tds_pkg::CMD_CLEAR, CMD_SPARE_HI),
                                              $urandom_range(0, SLOTS - 1), $urandom()));
                end
            end else begin
                run_episode();
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();
        run_random();
        s_valid <= 1'b0;

        // Let every listed task come out, then give the block time to show
        // any stray beat before the verdict.
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (tracker.mismatches == 0) begin
            $display("task_dependency_scoreboard_unit verification clean");
        end else begin
            $display("task_dependency_scoreboard_unit verification failed");
        end
        $finish;
    end

endmodule
